>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, muted while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication check: when cond holds, prop holds in the same cycle
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle check: when cond holds, prop holds in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/core/ihbr_pkg.sv
`default_nettype none

package ihbr_pkg;

	// Fixed field widths
	localparam int unsigned DUTY_W   = 10;
	localparam int unsigned SP_W     = 9;
	localparam int unsigned OFS_W    = 10;
	localparam int unsigned STEP_W   = 8;
	localparam int unsigned OT_W     = 10;
	localparam int unsigned MARGIN_W = 8;
	localparam int unsigned INTER_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_OFFSET  = 3'd0,
		REG_SETPOINT_STEP  = 3'd1,
		REG_SETPOINT_LIMIT = 3'd2,
		REG_OVERTEMP_LIMIT = 3'd3,
		REG_READY_MARGIN   = 3'd4
	} reg_idx_t;

	// Register reset values
	localparam logic [OFS_W-1:0]    RST_SENSOR_OFFSET  = 10'd50;
	localparam logic [STEP_W-1:0]   RST_SETPOINT_STEP  = 8'd50;
	localparam logic [SP_W-1:0]     RST_SETPOINT_LIMIT = 9'd490;
	localparam logic [OT_W-1:0]     RST_OVERTEMP_LIMIT = 10'd490;
	localparam logic [MARGIN_W-1:0] RST_READY_MARGIN   = 8'd20;

	// Duty levels
	localparam logic [DUTY_W-1:0] DUTY_OFF  = 10'd0;
	localparam logic [DUTY_W-1:0] DUTY_LOW  = 10'd400;
	localparam logic [DUTY_W-1:0] DUTY_MID  = 10'd500;
	localparam logic [DUTY_W-1:0] DUTY_HIGH = 10'd600;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd800;

	typedef struct packed {
		logic [OFS_W-1:0]    sensor_offset;
		logic [STEP_W-1:0]   setpoint_step;
		logic [SP_W-1:0]     setpoint_limit;
		logic [OT_W-1:0]     overtemp_limit;
		logic [MARGIN_W-1:0] ready_margin;
	} cfg_t;

	// Control state carried from one transaction to the next
	typedef struct packed {
		logic            last_a;
		logic [SP_W-1:0] setpoint;
		logic            armed;
		logic            lamp;
	} ctl_state_t;

	// Banded duty for a positive error (setpoint above temperature)
	function automatic logic [DUTY_W-1:0] band_duty(input logic [SP_W-1:0] err);
		logic [DUTY_W-1:0] d;
		d = DUTY_OFF;
		if (err inside {[9'd201:9'd479]})
			d = DUTY_FULL;
		else if (err inside {[9'd51:9'd200]})
			d = DUTY_HIGH;
		else if (err inside {[9'd11:9'd49]})
			d = DUTY_MID;
		else if (err inside {[9'd2:9'd4]})
			d = DUTY_LOW;
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/iron_heater_band_regulator_core.sv
`default_nettype none

// Heater band regulator. Each input transaction (sample, pin_a, pin_b) yields exactly one
// output transaction (duty, ready_lamp, target, measured). The duty comes from the
// temperature and setpoint left by the previous transaction; the sample is then
// offset-corrected into the new temperature, a falling edge of pin_a steps the setpoint,
// and the ready lamp and the overtemperature cutoff are applied. An accepted transaction
// waits in the input register until the result register is free or draining, then
// enters the result register and raises out_valid (input register, then result register);
// one transaction is accepted every cycle while out_stall is low, since the whole update
// is one pass of compare and add logic between those two registers. Configuration writes
// must be issued only while no transaction is in flight.
module iron_heater_band_regulator_core #(
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [SAMPLE_BITS-1:0]           sample,
	input  wire logic                             pin_a,
	input  wire logic                             pin_b,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [ihbr_pkg::DUTY_W-1:0]           duty,
	output logic                                  ready_lamp,
	output logic [ihbr_pkg::SP_W-1:0]             target,
	output logic [SAMPLE_BITS-1:0]                measured,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [ihbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ihbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	ihbr_pkg::cfg_t                  cfg_q;
	ihbr_pkg::ctl_state_t            st_q;
	ihbr_pkg::ctl_state_t            st_next;
	logic [SAMPLE_BITS-1:0]          temp_q;
	logic [SAMPLE_BITS-1:0]          temp_next;
	logic [ihbr_pkg::DUTY_W-1:0]     duty_next;

	logic                            valid_s1;
	logic [SAMPLE_BITS-1:0]          sample_s1;
	logic                            pin_a_s1;
	logic                            pin_b_s1;

	logic                            valid_s2;
	logic [ihbr_pkg::DUTY_W-1:0]     duty_s2;
	logic                            lamp_s2;
	logic [ihbr_pkg::SP_W-1:0]       target_s2;
	logic [SAMPLE_BITS-1:0]          measured_s2;

	logic                            advance;
	logic                            in_take;

	// Handshake: stage 1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_offset  <= ihbr_pkg::RST_SENSOR_OFFSET;
			cfg_q.setpoint_step  <= ihbr_pkg::RST_SETPOINT_STEP;
			cfg_q.setpoint_limit <= ihbr_pkg::RST_SETPOINT_LIMIT;
			cfg_q.overtemp_limit <= ihbr_pkg::RST_OVERTEMP_LIMIT;
			cfg_q.ready_margin   <= ihbr_pkg::RST_READY_MARGIN;
		end else if (cfg_we) begin
			case (ihbr_pkg::reg_idx_t'(cfg_index))
				ihbr_pkg::REG_SENSOR_OFFSET:
					cfg_q.sensor_offset  <= cfg_data[ihbr_pkg::OFS_W-1:0];
				ihbr_pkg::REG_SETPOINT_STEP:
					cfg_q.setpoint_step  <= cfg_data[ihbr_pkg::STEP_W-1:0];
				ihbr_pkg::REG_SETPOINT_LIMIT:
					cfg_q.setpoint_limit <= cfg_data[ihbr_pkg::SP_W-1:0];
				ihbr_pkg::REG_OVERTEMP_LIMIT:
					cfg_q.overtemp_limit <= cfg_data[ihbr_pkg::OT_W-1:0];
				ihbr_pkg::REG_READY_MARGIN:
					cfg_q.ready_margin   <= cfg_data[ihbr_pkg::MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
			pin_a_s1  <= pin_a;
			pin_b_s1  <= pin_b;
		end
	end

	// Update logic
	ihbr_step #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_step (
		.sample    (sample_s1),
		.pin_a     (pin_a_s1),
		.pin_b     (pin_b_s1),
		.cfg       (cfg_q),
		.st        (st_q),
		.temp      (temp_q),
		.st_next   (st_next),
		.temp_next (temp_next),
		.duty      (duty_next)
	);

	// Regulator state, committed as the transaction enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.last_a   <= 1'b0;
			st_q.setpoint <= '0;
			st_q.armed    <= 1'b1;
			st_q.lamp     <= 1'b0;
			temp_q        <= '0;
		end else if (advance) begin
			st_q   <= st_next;
			temp_q <= temp_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s2     <= duty_next;
			lamp_s2     <= st_next.lamp;
			target_s2   <= st_next.setpoint;
			measured_s2 <= temp_next;
		end
	end

	assign out_valid  = valid_s2;
	assign duty       = duty_s2;
	assign ready_lamp = lamp_s2;
	assign target     = target_s2;
	assign measured   = measured_s2;

	// Checks
	`ASSERT_CLK(a_lamp_armed_excl, st_q.lamp ^ st_q.armed,
		"lamp and armed must be exclusive")
	`ASSERT_IMPL(a_target_tracks_state, valid_s2,
		(target_s2 == st_q.setpoint) && (measured_s2 == temp_q),
		"result does not match committed state")
	`ASSERT_IMPL(a_duty_overtemp, valid_s2 && (duty_s2 != ihbr_pkg::DUTY_OFF),
		32'(measured_s2) <= 32'(cfg_q.overtemp_limit),
		"nonzero duty above overtemperature limit")
	`ASSERT_NEXT(a_advance_fills, advance, valid_s2,
		"advanced transaction missing from result register")

endmodule

`default_nettype wire

>>> rtl/core/ihbr_step.sv
`default_nettype none

// One regulator update: duty from the old state, new temperature, encoder step, lamp
module ihbr_step #(
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  wire logic [SAMPLE_BITS-1:0]     sample,
	input  wire logic                       pin_a,
	input  wire logic                       pin_b,
	input  wire ihbr_pkg::cfg_t             cfg,
	input  wire ihbr_pkg::ctl_state_t       st,
	input  wire logic [SAMPLE_BITS-1:0]     temp,
	output ihbr_pkg::ctl_state_t            st_next,
	output logic [SAMPLE_BITS-1:0]          temp_next,
	output logic [ihbr_pkg::DUTY_W-1:0]     duty
);

	// Common width for compares: covers the 16-bit intermediate setpoint plus sign
	localparam int unsigned EXT_W = ((SAMPLE_BITS > ihbr_pkg::INTER_W) ?
		SAMPLE_BITS : ihbr_pkg::INTER_W) + 2;

	logic [EXT_W-1:0]                 temp_x;
	logic [EXT_W-1:0]                 smp_x;
	logic [EXT_W-1:0]                 ofs_x;
	logic [EXT_W-1:0]                 corr_x;
	logic [EXT_W-1:0]                 tnew_x;
	logic [EXT_W-1:0]                 sp_x;
	logic [EXT_W-1:0]                 inter_x;
	logic [EXT_W-1:0]                 diff_x;
	logic [EXT_W-1:0]                 margin_x;
	logic [EXT_W-1:0]                 ot_x;
	logic [EXT_W-1:0]                 lim_x;
	logic [ihbr_pkg::INTER_W-1:0]     inter;
	logic [ihbr_pkg::SP_W-1:0]        err;
	logic [ihbr_pkg::DUTY_W-1:0]      band;

	// Zero-extended operands
	assign temp_x   = EXT_W'(temp);
	assign smp_x    = EXT_W'(sample);
	assign ofs_x    = EXT_W'(cfg.sensor_offset);
	assign sp_x     = EXT_W'(st.setpoint);
	assign margin_x = EXT_W'(cfg.ready_margin);
	assign ot_x     = EXT_W'(cfg.overtemp_limit);
	assign lim_x    = EXT_W'(cfg.setpoint_limit);

	// Banded duty from stored state; err only used when temp < setpoint (< 512)
	assign err  = st.setpoint - temp_x[ihbr_pkg::SP_W-1:0];
	assign band = (temp_x < sp_x) ? ihbr_pkg::band_duty(err) : ihbr_pkg::DUTY_OFF;

	// Offset correction of the new sample
	assign corr_x    = smp_x - ofs_x;
	assign tnew_x    = (smp_x > ofs_x) ? EXT_W'(corr_x[SAMPLE_BITS-1:0]) : smp_x;
	assign temp_next = tnew_x[SAMPLE_BITS-1:0];

	// Encoder: falling edge of A steps the setpoint, B selects direction (16-bit wrap)
	always_comb begin
		inter = ihbr_pkg::INTER_W'(st.setpoint);
		if (st.last_a && !pin_a) begin
			if (pin_b)
				inter = ihbr_pkg::INTER_W'(st.setpoint) -
					ihbr_pkg::INTER_W'(cfg.setpoint_step);
			else
				inter = ihbr_pkg::INTER_W'(st.setpoint) +
					ihbr_pkg::INTER_W'(cfg.setpoint_step);
		end
	end

	assign inter_x = EXT_W'(inter);
	assign diff_x  = inter_x - tnew_x;

	// Lamp, armed and setpoint update
	always_comb begin
		st_next        = st;
		st_next.last_a = pin_a;
		if ((tnew_x == inter_x) && st.armed) begin
			st_next.lamp  = 1'b1;
			st_next.armed = 1'b0;
		end else if ($signed(diff_x) > $signed(margin_x)) begin
			st_next.lamp  = 1'b0;
			st_next.armed = 1'b1;
		end
		st_next.setpoint = (inter_x > lim_x) ? '0 : inter[ihbr_pkg::SP_W-1:0];
	end

	// Overtemperature cutoff on the new temperature
	assign duty = (tnew_x > ot_x) ? ihbr_pkg::DUTY_OFF : band;

endmodule

`default_nettype wire

>>> tb/tb_iron_heater_band_regulator_core.sv
`timescale 1ns / 1ps

module tb_iron_heater_band_regulator_core;

	localparam int unsigned SAMPLE_BITS = 10;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	// highest index the config port can address; above REG_READY_MARGIN nothing is mapped
	localparam logic [ihbr_pkg::CFG_IDX_W-1:0] REG_IDX_TOP = '1;

	typedef struct packed {
		logic [ihbr_pkg::DUTY_W-1:0] duty;
		logic                        lamp;
		logic [ihbr_pkg::SP_W-1:0]   target;
		logic [SAMPLE_BITS-1:0]      measured;
	} regulation_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [SAMPLE_BITS-1:0]            sample;
	logic                              pin_a;
	logic                              pin_b;
	logic                              out_valid;
	logic                              out_stall;
	logic [ihbr_pkg::DUTY_W-1:0]       duty;
	logic                              ready_lamp;
	logic [ihbr_pkg::SP_W-1:0]         target;
	logic [SAMPLE_BITS-1:0]            measured;
	logic                              cfg_we;
	logic [ihbr_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [ihbr_pkg::CFG_DATA_W-1:0]   cfg_data;

	// predicted regulator state and register file
	ihbr_pkg::cfg_t                    pred_cfg;
	logic                              pred_last_a;
	logic [SAMPLE_BITS-1:0]            pred_temp;
	logic [ihbr_pkg::SP_W-1:0]         pred_setpoint;
	logic                              pred_armed;
	logic                              pred_lamp;

	regulation_t awaited_results[$];
	int unsigned fail_count;
	int unsigned cycles;
	bit          idle_on;
	bit          stall_on;

	iron_heater_band_regulator_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.pin_a     (pin_a),
		.pin_b     (pin_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty      (duty),
		.ready_lamp(ready_lamp),
		.target    (target),
		.measured  (measured),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One regulation step: duty from the old state, then new temperature,
	// encoder step, lamp, overtemperature cutoff and setpoint wrap.
	function automatic regulation_t regulate(input logic [SAMPLE_BITS-1:0] smp,
			input logic a, input logic b);
		regulation_t                  r;
		int                           err;
		int                           diff;
		logic [ihbr_pkg::INTER_W-1:0] inter;
		logic [ihbr_pkg::DUTY_W-1:0]  d;

		d = ihbr_pkg::DUTY_OFF;
		if (pred_temp < pred_setpoint) begin
			err = int'(pred_setpoint) - int'(pred_temp);
			if (err > 200 && err < 480)
				d = ihbr_pkg::DUTY_FULL;
			else if (err > 50 && err <= 200)
				d = ihbr_pkg::DUTY_HIGH;
			else if (err > 10 && err < 50)
				d = ihbr_pkg::DUTY_MID;
			else if (err > 1 && err < 5)
				d = ihbr_pkg::DUTY_LOW;
		end

		if (smp > pred_cfg.sensor_offset)
			smp = smp - pred_cfg.sensor_offset;
		pred_temp = smp;

		// 16-bit intermediate setpoint, wraps below zero
		inter = ihbr_pkg::INTER_W'(pred_setpoint);
		if (pred_last_a && !a) begin
			if (b)
				inter = inter - ihbr_pkg::INTER_W'(pred_cfg.setpoint_step);
			else
				inter = inter + ihbr_pkg::INTER_W'(pred_cfg.setpoint_step);
		end
		pred_last_a = a;

		diff = int'(inter) - int'(pred_temp);
		if (ihbr_pkg::INTER_W'(pred_temp) == inter && pred_armed) begin
			pred_lamp  = 1'b1;
			pred_armed = 1'b0;
		end else if (diff > int'(pred_cfg.ready_margin)) begin
			pred_armed = 1'b1;
			pred_lamp  = 1'b0;
		end

		if (pred_temp > pred_cfg.overtemp_limit)
			d = ihbr_pkg::DUTY_OFF;

		pred_setpoint = (inter > ihbr_pkg::INTER_W'(pred_cfg.setpoint_limit)) ?
			'0 : inter[ihbr_pkg::SP_W-1:0];

		r.duty     = d;
		r.lamp     = pred_lamp;
		r.target   = pred_setpoint;
		r.measured = pred_temp;
		return r;
	endfunction

	// Drive one input transaction, optionally after an idle burst
	task automatic send_item(input logic [SAMPLE_BITS-1:0] smp, input logic a, input logic b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		pin_a    <= a;
		pin_b    <= b;
		do
			@(posedge clk);
		while (in_stall);
		awaited_results.push_back(regulate(smp, a, b));
	endtask

	// Stop sending and let every awaited result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write every index, unmapped ones included; unused high data bits get noise
	task automatic load_config(input logic [ihbr_pkg::OFS_W-1:0] ofs,
			input logic [ihbr_pkg::STEP_W-1:0] stp,
			input logic [ihbr_pkg::SP_W-1:0] lim, input logic [ihbr_pkg::OT_W-1:0] ot,
			input logic [ihbr_pkg::MARGIN_W-1:0] mrg);
		int                              i;
		logic [ihbr_pkg::CFG_DATA_W-1:0] word;

		for (i = 0; i <= int'(REG_IDX_TOP); i++) begin
			word = ihbr_pkg::CFG_DATA_W'($urandom);
			case (i)
				ihbr_pkg::REG_SENSOR_OFFSET: begin
					word[ihbr_pkg::OFS_W-1:0] = ofs;
					pred_cfg.sensor_offset = ofs;
				end
				ihbr_pkg::REG_SETPOINT_STEP: begin
					word[ihbr_pkg::STEP_W-1:0] = stp;
					pred_cfg.setpoint_step = stp;
				end
				ihbr_pkg::REG_SETPOINT_LIMIT: begin
					word[ihbr_pkg::SP_W-1:0] = lim;
					pred_cfg.setpoint_limit = lim;
				end
				ihbr_pkg::REG_OVERTEMP_LIMIT: begin
					word[ihbr_pkg::OT_W-1:0] = ot;
					pred_cfg.overtemp_limit = ot;
				end
				ihbr_pkg::REG_READY_MARGIN: begin
					word[ihbr_pkg::MARGIN_W-1:0] = mrg;
					pred_cfg.ready_margin = mrg;
				end
				default: ;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= i[ihbr_pkg::CFG_IDX_W-1:0];
			cfg_data  <= word;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Random samples, mostly placed relative to the setpoint so the lamp and bands get exercised
	task automatic run_random(input int unsigned n);
		int unsigned k;
		int unsigned sel;
		int          t;
		int          s;

		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				if ($urandom_range(0, 1) == 0)
					t = int'(pred_setpoint) + int'($urandom_range(0, 16)) - 8;
				else
					t = int'(pred_setpoint) - int'($urandom_range(0, 500));
				s = (t < 1) ? 0 : t + int'(pred_cfg.sensor_offset);
				if (s > int'(SAMPLE_MAX))
					s = int'(SAMPLE_MAX);
			end else if (sel < 9) begin
				s = int'($urandom_range(0, SAMPLE_MAX));
			end else begin
				case ($urandom_range(0, 3))
					0: s = 0;
					1: s = int'(SAMPLE_MAX);
					2: s = int'(pred_cfg.sensor_offset);
					default: s = int'(pred_cfg.sensor_offset) + 1;
				endcase
				if (s > int'(SAMPLE_MAX))
					s = int'(SAMPLE_MAX);
			end
			send_item(SAMPLE_BITS'(s), 1'($urandom), 1'($urandom));
		end
	endtask

	// Reset registers: lamp at power-up, offset edge, overtemperature, setpoint underflow
	task automatic test_reset_sequence();
		send_item(SAMPLE_BITS'(0), 1'b1, 1'b0);
		send_item(SAMPLE_BITS'(SAMPLE_MAX), 1'b0, 1'b0);
		send_item(SAMPLE_BITS'(51), 1'b1, 1'b1);
		send_item(SAMPLE_BITS'(50), 1'b0, 1'b1);
		send_item(SAMPLE_BITS'(0), 1'b1, 1'b1);
		send_item(SAMPLE_BITS'(0), 1'b0, 1'b1);
		wait_idle();
	endtask

	// Zero offset, setpoint at 510, temperatures walked over every band edge
	task automatic test_duty_bands();
		int unsigned temps[15] = '{31, 30, 309, 310, 459, 460, 461, 499, 500,
			505, 506, 508, 509, 510, 511};

		load_config('0, 8'd255, 9'd511, 10'd1023, '0);
		send_item(SAMPLE_BITS'(0), 1'b1, 1'b0);
		send_item(SAMPLE_BITS'(0), 1'b0, 1'b0);
		send_item(SAMPLE_BITS'(0), 1'b1, 1'b0);
		send_item(SAMPLE_BITS'(0), 1'b0, 1'b0);
		foreach (temps[j])
			send_item(SAMPLE_BITS'(temps[j]), 1'b0, 1'b0);
		wait_idle();
	endtask

	// Random traffic under a series of register settings, extremes first
	task automatic test_config_sweep();
		int unsigned p;

		load_config('1, '1, '1, '1, '1);
		run_random(150);
		wait_idle();
		load_config('0, '0, '0, '0, '0);
		run_random(150);
		wait_idle();
		load_config(10'd50, 8'd10, 9'd490, 10'd490, 8'd20);
		run_random(300);
		wait_idle();
		for (p = 0; p < 4; p++) begin
			idle_on  = (p != 2);
			stall_on = (p != 1);
			load_config(ihbr_pkg::OFS_W'($urandom_range(0, 80)),
				ihbr_pkg::STEP_W'($urandom), ihbr_pkg::SP_W'($urandom),
				ihbr_pkg::OT_W'($urandom), ihbr_pkg::MARGIN_W'($urandom_range(0, 40)));
			run_random(150);
			wait_idle();
		end
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_back_to_back();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		load_config(ihbr_pkg::OFS_W'($urandom_range(0, 60)),
			ihbr_pkg::STEP_W'($urandom_range(1, 40)), 9'd490, 10'd490, 8'd20);
		run_random(250);
	endtask

	// Result checker
	always @(posedge clk) begin
		regulation_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result transaction: duty %0d target %0d measured %0d",
					duty, target, measured);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (duty !== want.duty) begin
					$error("duty: expected %0d, actual %0d", want.duty, duty);
					fail_count++;
				end
				if (ready_lamp !== want.lamp) begin
					$error("ready_lamp: expected %0d, actual %0d", want.lamp, ready_lamp);
					fail_count++;
				end
				if (target !== want.target) begin
					$error("target: expected %0d, actual %0d", want.target, target);
					fail_count++;
				end
				if (measured !== want.measured) begin
					$error("measured: expected %0d, actual %0d", want.measured, measured);
					fail_count++;
				end
			end
		end
	end

	// Output-side backpressure in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("iron_heater_band_regulator_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sample        = '0;
		pin_a         = 1'b0;
		pin_b         = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		cycles        = 0;
		fail_count    = 0;
		idle_on       = 1'b1;
		stall_on      = 1'b1;
		pred_cfg      = '{ihbr_pkg::RST_SENSOR_OFFSET, ihbr_pkg::RST_SETPOINT_STEP,
			ihbr_pkg::RST_SETPOINT_LIMIT, ihbr_pkg::RST_OVERTEMP_LIMIT,
			ihbr_pkg::RST_READY_MARGIN};
		pred_last_a   = 1'b0;
		pred_temp     = '0;
		pred_setpoint = '0;
		pred_armed    = 1'b1;
		pred_lamp     = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sequence();
		test_duty_bands();
		test_config_sweep();
		test_back_to_back();

		wait_idle();
		if (fail_count == 0)
			$display("iron_heater_band_regulator_core: match");
		else
			$display("iron_heater_band_regulator_core: mismatch");
		$finish;
	end

endmodule
